@@ sv/command_line_tokenizer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the command line tokeniser
// Concurrent checks clocked on clk; one variant is gated by reset.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_UNIT_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CLTOK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CLTOK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLTOK_ASSERT(label, prop, msg)
`define CLTOK_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ sv/cltok_pkg.sv @@
// ----------------------------------------------------------------------------
// cltok_pkg
// Shared types and character constants for the command line tokeniser.
// ----------------------------------------------------------------------------
`default_nettype none

package cltok_pkg;

  typedef struct packed {
    logic       has_char;
    logic [7:0] out_char;
    logic       part_end;
    logic       msg_end;
  } cltok_item_t;

  typedef struct packed {
    cltok_item_t first;
    cltok_item_t second;
    logic [1:0]  count;
  } cltok_push_t;

  localparam logic [7:0] SEP_MAX   = 8'd32;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // token heads, first character in the low byte
  localparam logic [39:0] HEAD_VEC  = 40'h00_3A63_6576;
  localparam logic [39:0] HEAD_ROT  = 40'h00_3A74_6F72;
  localparam logic [39:0] HEAD_FN   = 40'h00_003A_6E66;
  localparam logic [39:0] HEAD_NAME = 40'h3A_656D_616E;
  localparam logic [39:0] HEAD_VAR  = 40'h00_3A72_6176;

  localparam logic [2:0] LEN_FN   = 3'd3;
  localparam logic [2:0] LEN_WORD = 3'd4;
  localparam logic [2:0] LEN_NAME = 3'd5;
  localparam logic [2:0] LEN_HEAD = 3'd5;
  localparam logic [2:0] LEN_SAT  = 3'd7;

  localparam logic [1:0] LIST_JOINS = 2'd3;
  localparam logic [1:0] ONE_JOINS  = 2'd1;

endpackage

`default_nettype wire

@@ sv/cltok_scan.sv @@
// ----------------------------------------------------------------------------
// cltok_scan
// Input register and single-pass scanner: decodes one byte per cycle when
// the queue has room into at most two result requests; updates token state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "command_line_tokenizer_unit_defines.svh"

module cltok_scan (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_byte,
  input  wire logic                  msg_last,
  input  wire logic                  room,
  output cltok_pkg::cltok_push_t     push
);
  import cltok_pkg::*;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_BARE    = 2'd1,
    MODE_QUOTED  = 2'd2,
    MODE_ESCAPE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    JOIN_NONE = 2'd0,
    JOIN_LIST = 2'd1,
    JOIN_ONE  = 2'd2
  } join_t;

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_last;

  mode_t       scan_mode, scan_mode_next;
  logic        quote_is_double, quote_is_double_next;
  logic [39:0] token_head, token_head_next;
  logic [2:0]  token_length, token_length_next;
  join_t       join_kind, join_kind_next;
  logic [1:0]  joins_left, joins_left_next;
  logic [7:0]  last_emitted, last_emitted_next;
  logic        part_open, part_open_next;

  logic        fire;
  logic        comma, chr_ok, end_tok, close;
  logic [7:0]  chr, quote_char;
  logic [39:0] head_base;
  logic [2:0]  len_base;
  logic [1:0]  jl_dec, cnt;
  cltok_item_t itm [2];

  assign fire     = hold_valid && room;
  assign in_ready = !hold_valid || room;

  always_comb begin
    scan_mode_next       = scan_mode;
    quote_is_double_next = quote_is_double;
    join_kind_next       = join_kind;
    joins_left_next      = joins_left;
    last_emitted_next    = last_emitted;
    part_open_next       = part_open;
    comma      = 1'b0;
    chr_ok     = 1'b0;
    end_tok    = 1'b0;
    close      = 1'b0;
    chr        = hold_byte;
    quote_char = quote_is_double ? CH_DQUOTE : CH_SQUOTE;
    head_base  = token_head;
    len_base   = token_length;
    jl_dec     = joins_left;

    unique case (scan_mode)
      MODE_BETWEEN: begin
        if (hold_byte > SEP_MAX) begin
          comma = (join_kind == JOIN_LIST) && (last_emitted != CH_COLON);
          if (join_kind == JOIN_NONE) begin
            part_open_next = 1'b1;
            head_base      = '0;
            len_base       = '0;
          end
          if (hold_byte == CH_DQUOTE || hold_byte == CH_SQUOTE) begin
            scan_mode_next       = MODE_QUOTED;
            quote_is_double_next = (hold_byte == CH_DQUOTE);
          end else begin
            scan_mode_next = MODE_BARE;
            chr_ok         = 1'b1;
          end
        end
      end
      MODE_BARE: begin
        if (hold_byte <= SEP_MAX) end_tok = 1'b1;
        else chr_ok = 1'b1;
      end
      MODE_QUOTED: begin
        if (hold_byte == quote_char) begin
          end_tok = 1'b1;
        end else if (hold_byte == CH_BSLASH && !hold_last) begin
          scan_mode_next = MODE_ESCAPE;
        end else begin
          chr_ok = 1'b1;
        end
      end
      MODE_ESCAPE: begin
        case (hold_byte)
          CH_N:    chr = CH_LF;
          CH_T:    chr = CH_TAB;
          CH_R:    chr = CH_CR;
          CH_ZERO: chr = CH_NUL;
          default: chr = hold_byte;
        endcase
        chr_ok         = 1'b1;
        scan_mode_next = MODE_QUOTED;
      end
      default: scan_mode_next = MODE_BETWEEN;
    endcase

    token_head_next   = head_base;
    token_length_next = len_base;

    if (comma) last_emitted_next = CH_COMMA;
    if (chr_ok) begin
      last_emitted_next = chr;
      if (join_kind == JOIN_NONE) begin
        if (len_base < LEN_HEAD)
          token_head_next = head_base | ({32'd0, chr} << {len_base, 3'b000});
        if (len_base != LEN_SAT)
          token_length_next = len_base + 3'd1;
      end
    end

    if (end_tok) begin
      scan_mode_next = MODE_BETWEEN;
      if (join_kind == JOIN_NONE) begin
        if (token_length == LEN_WORD &&
            (token_head == HEAD_VEC || token_head == HEAD_ROT)) begin
          join_kind_next  = JOIN_LIST;
          joins_left_next = LIST_JOINS;
        end else if ((token_length == LEN_FN && token_head == HEAD_FN) ||
                     (token_length == LEN_NAME && token_head == HEAD_NAME) ||
                     (token_length == LEN_WORD && token_head == HEAD_VAR)) begin
          join_kind_next  = JOIN_ONE;
          joins_left_next = ONE_JOINS;
        end else begin
          close = 1'b1;
        end
      end else begin
        if (joins_left != 2'd0) jl_dec = joins_left - 2'd1;
        joins_left_next = jl_dec;
        if (jl_dec == 2'd0) close = 1'b1;
      end
    end

    if (close) begin
      part_open_next  = 1'b0;
      join_kind_next  = JOIN_NONE;
      joins_left_next = 2'd0;
    end

    itm[0] = '0;
    itm[1] = '0;
    cnt    = 2'd0;
    if (comma) begin
      itm[0].has_char = 1'b1;
      itm[0].out_char = CH_COMMA;
      cnt = 2'd1;
    end
    if (chr_ok) begin
      itm[cnt[0]].has_char = 1'b1;
      itm[cnt[0]].out_char = chr;
      cnt = cnt + 2'd1;
    end
    if (close) begin
      itm[cnt[0]].part_end = 1'b1;
      cnt = cnt + 2'd1;
    end
    if (hold_last) begin
      if (part_open_next) begin
        if (cnt != 2'd0) begin
          itm[cnt[1]].part_end = 1'b1;
        end else begin
          itm[0].part_end = 1'b1;
          cnt = 2'd1;
        end
      end
      if (cnt == 2'd0) cnt = 2'd1;
      itm[cnt[1]].msg_end = 1'b1;
    end

    push.first  = itm[0];
    push.second = itm[1];
    push.count  = fire ? cnt : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
      hold_last <= msg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && hold_last)) begin
      scan_mode       <= MODE_BETWEEN;
      quote_is_double <= 1'b0;
      token_head      <= '0;
      token_length    <= '0;
      join_kind       <= JOIN_NONE;
      joins_left      <= '0;
      last_emitted    <= '0;
      part_open       <= 1'b0;
    end else if (fire) begin
      scan_mode       <= scan_mode_next;
      quote_is_double <= quote_is_double_next;
      token_head      <= token_head_next;
      token_length    <= token_length_next;
      join_kind       <= join_kind_next;
      joins_left      <= joins_left_next;
      last_emitted    <= last_emitted_next;
      part_open       <= part_open_next;
    end
  end

  `CLTOK_ASSERT(a_last_resets, (fire && hold_last) |=> (scan_mode == MODE_BETWEEN && !part_open && join_kind == JOIN_NONE), "state not cleared after message end")
  `CLTOK_ASSERT(a_last_pushes, (fire && hold_last) |-> (push.count != 2'd0), "message end produced no request")
  `CLTOK_ASSERT(a_pair_is_comma, (push.count == 2'd2) |-> (push.first.has_char && push.second.has_char && push.first.out_char == CH_COMMA), "double request is not separator plus character")

endmodule

`default_nettype wire

@@ sv/cltok_outq.sv @@
// ----------------------------------------------------------------------------
// cltok_outq
// Four-entry result queue: takes up to two requests per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "command_line_tokenizer_unit_defines.svh"

module cltok_outq (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cltok_pkg::cltok_push_t push,
  output logic                        room,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output cltok_pkg::cltok_item_t      head
);
  import cltok_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  cltok_item_t       entries [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [PW:0]       count, count_next;
  logic              pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= (PW+1)'(DEPTH - 2));
  assign head      = entries[rd_ptr];

  always_comb begin
    count_next = count + {{(PW-1){1'b0}}, push.count} - {{PW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count[PW-1:0];
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr + 1'b1] <= push.second;
  end

  `CLTOK_ASSERT(a_no_overfill, (push.count != 2'd0) |-> (count <= (PW+1)'(DEPTH - 2)), "request pushed into a full queue")
  `CLTOK_ASSERT(a_head_held, (out_valid && !out_ready) |=> (out_valid && $stable(head)), "queue head changed while stalled")
  `CLTOK_ASSERT(a_count_range, count <= (PW+1)'(DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

@@ sv/command_line_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit
// Shell-style tokeniser: bytes of a command message in, part characters out.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with in_byte and msg_last (final byte).
// Output channel: out_valid/out_ready with has_char, out_char, part_end and
// msg_end; each byte yields zero, one or two results, and every message
// ends in exactly one result with msg_end set.
// A taken byte waits in the input register, is decoded there once the queue
// has room, and its results are written into the queue and offered from it.
// Throughput: one byte per cycle; the scanner decodes a byte whenever the
// four-entry result queue has two free slots; the queue drains one result
// per cycle while out_ready is high, so only bytes that raise two results
// (a separator comma plus a character) can hold the input back.
// Reset (rst, synchronous) empties the input register and the queue and
// returns the scanner to its between-tokens state. A stalled receiver holds
// the head result steady; the queue fills until under two slots are free,
// then the input register fills, then in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module command_line_tokenizer_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       msg_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            has_char,
  output logic [7:0]      out_char,
  output logic            part_end,
  output logic            msg_end
);
  import cltok_pkg::*;

  cltok_push_t push;
  cltok_item_t head;
  logic        room;

  cltok_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .msg_last (msg_last),
    .room     (room),
    .push     (push)
  );

  cltok_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign has_char = head.has_char;
  assign out_char = head.out_char;
  assign part_end = head.part_end;
  assign msg_end  = head.msg_end;

endmodule

`default_nettype wire

@@ tb/sv/cltok_checker.sv @@
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// cltok_checker
// Watches the request and result channels of the command line tokeniser,
// predicts the result stream from every accepted request byte and compares
// each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module cltok_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       msg_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       has_char,
  input  logic [7:0] out_char,
  input  logic       part_end,
  input  logic       msg_end,
  output int         mismatch_count,
  output int         results_due
);
  import cltok_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef enum logic [1:0] {SCAN_GAP, SCAN_WORD, SCAN_QUOTE, SCAN_ESC} scan_state_t;
  typedef enum logic [1:0] {LINK_NONE, LINK_LIST, LINK_SINGLE} link_kind_t;

  scan_state_t scan;
  logic        dquote;
  logic [39:0] head;
  logic [2:0]  head_len;
  link_kind_t  link;
  logic [1:0]  links_left;
  logic [7:0]  prev_char;
  logic        part_active;

  cltok_item_t step_q[$];
  cltok_item_t due_q[$];
  cltok_item_t want;

  function automatic void clear_scanner();
    scan        = SCAN_GAP;
    dquote      = 1'b0;
    head        = '0;
    head_len    = '0;
    link        = LINK_NONE;
    links_left  = '0;
    prev_char   = '0;
    part_active = 1'b0;
  endfunction

  function automatic void push_item(logic has, logic [7:0] ch, logic pend);
    cltok_item_t it;
    it.has_char = has;
    it.out_char = has ? ch : 8'h00;
    it.part_end = pend;
    it.msg_end  = 1'b0;
    step_q = {step_q, it};
  endfunction

  function automatic void emit_char(logic [7:0] ch);
    push_item(1'b1, ch, 1'b0);
    prev_char = ch;
    if (link == LINK_NONE) begin
      if (head_len < LEN_HEAD) head[8 * head_len +: 8] = ch;
      if (head_len < LEN_SAT) head_len = head_len + 3'd1;
    end
  endfunction

  function automatic void close_part();
    push_item(1'b0, 8'h00, 1'b1);
    part_active = 1'b0;
    link        = LINK_NONE;
    links_left  = '0;
  endfunction

  function automatic void end_token();
    scan = SCAN_GAP;
    if (link == LINK_NONE) begin
      if (head_len == LEN_WORD && (head == HEAD_VEC || head == HEAD_ROT)) begin
        link       = LINK_LIST;
        links_left = LIST_JOINS;
      end else if ((head_len == LEN_FN && head == HEAD_FN) ||
                   (head_len == LEN_NAME && head == HEAD_NAME) ||
                   (head_len == LEN_WORD && head == HEAD_VAR)) begin
        link       = LINK_SINGLE;
        links_left = ONE_JOINS;
      end else begin
        close_part();
      end
    end else begin
      if (links_left != 2'd0) links_left = links_left - 2'd1;
      if (links_left == 2'd0) close_part();
    end
  endfunction

  function automatic void tokenise_byte(logic [7:0] b, logic last);
    cltok_item_t tail;
    step_q.delete();
    case (scan)
      SCAN_GAP: begin
        if (b > SEP_MAX) begin
          if (link == LINK_LIST && prev_char != CH_COLON) begin
            push_item(1'b1, CH_COMMA, 1'b0);
            prev_char = CH_COMMA;
          end
          if (link == LINK_NONE) begin
            part_active = 1'b1;
            head        = '0;
            head_len    = '0;
          end
          if (b == CH_DQUOTE || b == CH_SQUOTE) begin
            scan   = SCAN_QUOTE;
            dquote = (b == CH_DQUOTE);
          end else begin
            scan = SCAN_WORD;
            emit_char(b);
          end
        end
      end
      SCAN_WORD: begin
        if (b <= SEP_MAX) end_token();
        else emit_char(b);
      end
      SCAN_QUOTE: begin
        if (b == (dquote ? CH_DQUOTE : CH_SQUOTE)) end_token();
        else if (b == CH_BSLASH && !last) scan = SCAN_ESC;
        else emit_char(b);
      end
      default: begin
        case (b)
          CH_N:    emit_char(CH_LF);
          CH_T:    emit_char(CH_TAB);
          CH_R:    emit_char(CH_CR);
          CH_ZERO: emit_char(CH_NUL);
          default: emit_char(b);
        endcase
        scan = SCAN_QUOTE;
      end
    endcase

    if (last) begin
      if (part_active) begin
        if (step_q.size() > 0) begin
          tail = step_q.pop_back();
          tail.part_end = 1'b1;
          step_q = {step_q, tail};
        end else begin
          push_item(1'b0, 8'h00, 1'b1);
        end
      end
      if (step_q.size() == 0) push_item(1'b0, 8'h00, 1'b0);
      tail = step_q.pop_back();
      tail.msg_end = 1'b1;
      step_q = {step_q, tail};
      clear_scanner();
    end

    foreach (step_q[i]) due_q = {due_q, step_q[i]};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_scanner();
      due_q.delete();
      mismatch_count = 0;
    end else begin
      if (in_valid && in_ready) tokenise_byte(in_byte, msg_last);
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result %0b/%02h/%0b/%0b",
                     $time, has_char, out_char, part_end, msg_end);
        end else begin
          want = due_q.pop_front();
          if (has_char !== want.has_char || out_char !== want.out_char ||
              part_end !== want.part_end || msg_end !== want.msg_end) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: mismatch: expected %0b/%02h/%0b/%0b got %0b/%02h/%0b/%0b",
                       $time, want.has_char, want.out_char, want.part_end, want.msg_end,
                       has_char, out_char, part_end, msg_end);
          end
        end
      end
    end
    results_due = due_q.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// testbench
// Feeds command messages to the tokeniser: a few hand-written ones, then
// random messages built from plain, quoted and escaped tokens, join words
// and stray bytes. Both channels idle at random and the result side holds
// off for long stretches; the checker alongside predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import cltok_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_REQUESTS = 1200;
  localparam int TAIL_CYCLES     = 20;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       msg_last  = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       has_char;
  logic [7:0] out_char;
  logic       part_end;
  logic       msg_end;

  int mismatch_count;
  int results_due;

  int   tx_sent       = 0;
  logic tx_quiet      = 1'b0;
  int   hold_off_asked = 0;
  logic [7:0] msg[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  command_line_tokenizer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .msg_last  (msg_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .has_char  (has_char),
    .out_char  (out_char),
    .part_end  (part_end),
    .msg_end   (msg_end)
  );

  cltok_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .msg_last       (msg_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .has_char       (has_char),
    .out_char       (out_char),
    .part_end       (part_end),
    .msg_end        (msg_end),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  function automatic string vocab_word(int k);
    case (k)
      0:       return "vec:";
      1:       return "rot:";
      2:       return "fn:";
      3:       return "name:";
      4:       return "var:";
      5:       return "vec";
      6:       return "rot::";
      7:       return "fn:x";
      8:       return "names:";
      9:       return "var";
      10:      return "VEC:";
      default: return "nam:";
    endcase
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) msg = {msg, s[i]};
  endfunction

  function automatic void add_separators();
    logic [7:0] c;
    repeat ($urandom_range(1, 2)) begin
      c = 8'($urandom_range(32));
      msg = {msg, c};
    end
  endfunction

  function automatic void build_random_message();
    int tokens;
    int kind;
    int n;
    logic [7:0] c;
    logic [7:0] q;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        c = 8'($urandom_range(255));
        msg = {msg, c};
      end
    end else begin
      if ($urandom_range(3) == 0) add_separators();
      tokens = $urandom_range(1, 6);
      for (int t = 0; t < tokens; t++) begin
        if (t > 0) add_separators();
        kind = (t == 0 && $urandom_range(1) == 1) ? 0 : $urandom_range(4);
        q = ($urandom_range(1) == 1) ? CH_DQUOTE : CH_SQUOTE;
        case (kind)
          0: add_text(vocab_word($urandom_range(4)));
          1: add_text(vocab_word($urandom_range(5, 11)));
          2: begin
            do c = 8'($urandom_range(33, 255)); while (c == CH_DQUOTE || c == CH_SQUOTE);
            msg = {msg, c};
            n = $urandom_range(0, 8);
            repeat (n) begin
              c = 8'($urandom_range(33, 255));
              msg = {msg, c};
            end
          end
          3: begin
            msg = {msg, q};
            n = $urandom_range(0, 6);
            repeat (n) begin
              if ($urandom_range(3) == 0) begin
                msg = {msg, CH_BSLASH};
                case ($urandom_range(5))
                  0:       c = CH_N;
                  1:       c = CH_T;
                  2:       c = CH_R;
                  3:       c = CH_ZERO;
                  4:       c = q;
                  default: c = 8'($urandom_range(255));
                endcase
              end else begin
                do c = 8'($urandom_range(255)); while (c == q || c == CH_BSLASH);
              end
              msg = {msg, c};
            end
            if (t < tokens - 1 || $urandom_range(3) != 0) msg = {msg, q};
            else if ($urandom_range(2) == 0) msg = {msg, CH_BSLASH};
          end
          default: begin
            msg = {msg, q};
            add_text(vocab_word($urandom_range(11)));
            msg = {msg, q};
          end
        endcase
      end
      if ($urandom_range(1) == 1) add_separators();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (tx_sent % 32 == 0) tx_quiet = ($urandom_range(3) == 0);
    gap = tx_quiet ? 0 : $urandom_range(10);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    msg_last <= last;
    do @(posedge clk); while (!in_ready);
    tx_sent++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
    msg.delete();
  endtask

  initial begin : receiver
    int stall;
    int taken;
    int hold_off_done;
    logic rx_quiet;
    taken         = 0;
    hold_off_done = 0;
    rx_quiet      = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_done != hold_off_asked) begin
        hold_off_done = hold_off_asked;
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      if (taken % 32 == 0) rx_quiet = ($urandom_range(3) == 0);
      stall = rx_quiet ? 0 : $urandom_range(10);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("** command_line_tokenizer_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int msg_count;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    msg = {msg, 8'h00};
    send_message();
    add_text("''");
    send_message();
    add_text("\"\\n\\t\\r\\0\\");
    send_message();
    add_text("vec: a: b");
    send_message();
    add_text("fn: ");
    msg = {msg, 8'hFF};
    send_message();

    msg_count = 0;
    while (tx_sent < RANDOM_REQUESTS) begin
      msg_count++;
      if (msg_count == 15 || msg_count == 150) hold_off_asked++;
      build_random_message();
      send_message();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    do @(negedge clk); while (results_due != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("** command_line_tokenizer_unit: PASSED **");
    else
      $display("** command_line_tokenizer_unit: FAILED **");
    $finish;
  end

endmodule
